FILE: hdl/stbi_pkg.sv
package stbi_pkg;

  // Word width of every table field and of the query fields.
  localparam int unsigned DataW = 32;

  // Default number of calibration points.
  localparam int unsigned TableDepthDef = 256;

  // Search window, 999.0 in Q16.16.
  localparam logic [DataW-1:0] Window = 32'd999 << 16;

  // Configuration register indexes.
  localparam logic [1:0] RegSlide = 2'd0;
  localparam logic [1:0] RegWiden = 2'd1;

  // Saturate a wide signed value to a signed 32-bit word.
  function automatic logic [DataW-1:0] sat32(input logic signed [63:0] v);
    logic [DataW-1:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hdl/scattered_table_bilinear_interp_unit.sv
// Bilinear lookup over a scattered table of calibration points. After reset the
// table is cleared one entry a cycle with busy_o high. A query reads the whole
// table through the single read port up to four times (two angle searches, one
// distance search for each of the two angles found) and runs up to three
// interpolations on the shared multiply and divide unit. The result is shown
// for one cycle under result_valid_o and must be taken then; the receiver
// cannot stall the block.
module scattered_table_bilinear_interp_unit #(
  parameter int unsigned TableDepth = stbi_pkg::TableDepthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              operation_i,
  input  logic [7:0]                        entry_index_i,
  input  logic signed [stbi_pkg::DataW-1:0] entry_distance_i,
  input  logic signed [stbi_pkg::DataW-1:0] entry_angle_i,
  input  logic signed [stbi_pkg::DataW-1:0] entry_ratio_i,
  input  logic signed [stbi_pkg::DataW-1:0] query_angle_i,
  input  logic signed [stbi_pkg::DataW-1:0] query_distance_i,
  output logic                              result_valid_o,
  output logic signed [stbi_pkg::DataW-1:0] interpolated_ratio_o,
  output logic                              single_angle_used_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [1:0]                        cfg_index_i,
  input  logic [15:0]                       cfg_data_i
);
  import stbi_pkg::*;

  localparam int unsigned AddrW = $clog2(TableDepth);
  localparam int unsigned CntW  = $clog2(TableDepth + 1);
  localparam int unsigned RamW  = 3 * DataW;

  localparam logic [3:0] SClear = 4'd0;
  localparam logic [3:0] SIdle  = 4'd1;
  localparam logic [3:0] SWr    = 4'd2;
  localparam logic [3:0] SA1    = 4'd3;
  localparam logic [3:0] SA1End = 4'd4;
  localparam logic [3:0] SA2    = 4'd5;
  localparam logic [3:0] SA2End = 4'd6;
  localparam logic [3:0] SD     = 4'd7;
  localparam logic [3:0] SDEnd  = 4'd8;
  localparam logic [3:0] SLerpD = 4'd9;
  localparam logic [3:0] SDFin  = 4'd10;
  localparam logic [3:0] SLerpA = 4'd11;

  logic [3:0]            st_q, st_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic signed [11:0]    slide_q;
  logic [15:0]           widen_q;
  logic                  ovld_q, ovld_d, osgl_q, osgl_d;
  logic [DataW-1:0]      ores_q, ores_d;

  logic [AddrW-1:0]      waddr_q, waddr_d;
  logic [RamW-1:0]       wdata_q, wdata_d;
  logic [DataW-1:0]      a_q, a_d, qd_q, qd_d;
  logic [DataW-1:0]      m1_q, m1_d, m2_q, m2_d;
  logic                  f1_q, f1_d, f2_q, f2_d;
  logic [DataW-1:0]      ang1_q, ang1_d, alo_q, alo_d, ahi_q, ahi_d;
  logic [DataW-1:0]      p1d_q, p1d_d, p1r_q, p1r_d, p2d_q, p2d_d, p2r_q, p2r_d;
  logic [DataW-1:0]      rlo_q, rlo_d, dval_q, dval_d;
  logic                  side_q, side_d, single_q, single_d;

  logic                  ram_we;
  logic [AddrW-1:0]      ram_waddr;
  logic [RamW-1:0]       ram_wdata;
  logic [RamW-1:0]       rdata;
  logic signed [DataW-1:0] rd_dist, rd_ang, rd_rat;
  logic signed [DataW+1:0] ad_diff, dd_diff, qa;
  logic [DataW-1:0]      ad_abs, dd_abs, cur_ang;
  logic [31:0]           idx_ext;
  logic signed [48:0]    wprod;
  logic signed [40:0]    wsh;

  logic [DataW-1:0]      s_d, s_r, dlo, dhi, rlo, rhi;
  logic                  l_start, l_done;
  logic signed [DataW-1:0] l_r0, l_r1;
  logic signed [DataW:0]   l_num;
  logic [DataW-1:0]      l_den;
  logic signed [63:0]    l_res;

  // Configuration port, always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slide_q <= '0;
      widen_q <= 16'd256;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegSlide: slide_q <= cfg_data_i[11:0];
        RegWiden: widen_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  stbi_ram #(
    .Width (RamW),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (cnt_q[AddrW-1:0]),
    .rdata_o (rdata)
  );

  // Clearing pass and entry writes share the write port.
  assign ram_we    = (st_q == SClear) || (st_q == SWr);
  assign ram_waddr = (st_q == SClear) ? cnt_q[AddrW-1:0] : waddr_q;
  assign ram_wdata = (st_q == SClear) ? '0 : wdata_q;

  // Table word fields and the two distances used by the scans.
  assign rd_dist = rdata[3*DataW-1:2*DataW];
  assign rd_ang  = rdata[2*DataW-1:DataW];
  assign rd_rat  = rdata[DataW-1:0];
  assign ad_diff = {2'b00, a_q} - {{2{rd_ang[DataW-1]}}, rd_ang};
  assign ad_abs  = ad_diff[DataW+1] ? DataW'(-ad_diff) : ad_diff[DataW-1:0];
  assign dd_diff = {{2{qd_q[DataW-1]}}, qd_q} - {{2{rd_dist[DataW-1]}}, rd_dist};
  assign dd_abs  = dd_diff[DataW+1] ? DataW'(-dd_diff) : dd_diff[DataW-1:0];
  assign cur_ang = side_q ? ahi_q : alo_q;

  // Write path: widen the angle, floor shift by 8, saturate.
  assign idx_ext = 32'(entry_index_i);
  assign wprod   = $signed(entry_angle_i) * $signed({1'b0, widen_q});
  assign wsh     = 41'(wprod >>> 8);

  // Query angle: subtract the slide in whole units, absolute value, saturate.
  assign qa = {{2{query_angle_i[DataW-1]}}, query_angle_i}
            - ({{22{slide_q[11]}}, slide_q} <<< 16);

  // Two nearest points of one angle, ordered by distance.
  always_comb begin
    s_d = f2_q ? p2d_q : p1d_q;
    s_r = f2_q ? p2r_q : p1r_q;
    if ($signed(p1d_q) > $signed(s_d)) begin
      dlo = s_d;   rlo = s_r;
      dhi = p1d_q; rhi = p1r_q;
    end else begin
      dlo = p1d_q; rlo = p1r_q;
      dhi = s_d;   rhi = s_r;
    end
  end

  // Interpolation unit operands: distance step or final angle step.
  always_comb begin
    if (st_q == SDFin) begin
      l_r0  = rlo_q;
      l_r1  = dval_q;
      l_num = {1'b0, a_q} - {alo_q[DataW-1], alo_q};
      l_den = DataW'({ahi_q[DataW-1], ahi_q} - {alo_q[DataW-1], alo_q});
    end else begin
      l_r0  = rlo;
      l_r1  = rhi;
      l_num = {qd_q[DataW-1], qd_q} - {dlo[DataW-1], dlo};
      l_den = DataW'({dhi[DataW-1], dhi} - {dlo[DataW-1], dlo});
    end
  end

  stbi_lerp u_lerp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (l_start),
    .r0_i    (l_r0),
    .r1_i    (l_r1),
    .num_i   (l_num),
    .den_i   (l_den),
    .done_o  (l_done),
    .res_o   (l_res)
  );

  // Sequencer.
  always_comb begin
    st_d     = st_q;
    cnt_d    = cnt_q;
    ovld_d   = 1'b0;
    osgl_d   = osgl_q;
    ores_d   = ores_q;
    waddr_d  = waddr_q;
    wdata_d  = wdata_q;
    a_d      = a_q;
    qd_d     = qd_q;
    m1_d     = m1_q;
    m2_d     = m2_q;
    f1_d     = f1_q;
    f2_d     = f2_q;
    ang1_d   = ang1_q;
    alo_d    = alo_q;
    ahi_d    = ahi_q;
    p1d_d    = p1d_q;
    p1r_d    = p1r_q;
    p2d_d    = p2d_q;
    p2r_d    = p2r_q;
    rlo_d    = rlo_q;
    dval_d   = dval_q;
    side_d   = side_q;
    single_d = single_q;
    l_start  = 1'b0;
    case (st_q)
      SClear: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(TableDepth - 1)) begin
          st_d = SIdle;
        end
      end
      SIdle: begin
        if (start_i) begin
          cnt_d = '0;
          if (!operation_i) begin
            waddr_d = idx_ext[AddrW-1:0];
            wdata_d = {entry_distance_i, sat32(64'(wsh)), entry_ratio_i};
            if (idx_ext < 32'(TableDepth)) begin
              st_d = SWr;
            end
          end else begin
            if (qa[DataW+1]) begin
              a_d = sat32(64'(-qa));
            end else begin
              a_d = sat32(64'(qa));
            end
            qd_d = query_distance_i;
            m1_d = Window;
            m2_d = Window;
            f1_d = 1'b0;
            f2_d = 1'b0;
            st_d = SA1;
          end
        end
      end
      SWr: st_d = SIdle;
      SA1: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q != '0 && ad_abs < m1_q) begin
          m1_d   = ad_abs;
          ang1_d = rd_ang;
          f1_d   = 1'b1;
        end
        if (cnt_q == CntW'(TableDepth)) begin
          st_d = SA1End;
        end
      end
      SA1End: begin
        cnt_d = '0;
        if (!f1_q) begin
          ovld_d = 1'b1;
          ores_d = '0;
          osgl_d = 1'b1;
          st_d   = SIdle;
        end else begin
          st_d = SA2;
        end
      end
      SA2: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q != '0 && ad_abs < m2_q && rd_ang != ang1_q) begin
          m2_d  = ad_abs;
          ahi_d = rd_ang;
          f2_d  = 1'b1;
        end
        if (cnt_q == CntW'(TableDepth)) begin
          st_d = SA2End;
        end
      end
      SA2End: begin
        cnt_d    = '0;
        single_d = !f2_q;
        side_d   = 1'b0;
        if (!f2_q || $signed(ang1_q) < $signed(ahi_q)) begin
          alo_d = ang1_q;
        end else begin
          alo_d = ahi_q;
          ahi_d = ang1_q;
        end
        m1_d = Window;
        m2_d = Window;
        f1_d = 1'b0;
        f2_d = 1'b0;
        st_d = SD;
      end
      SD: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q != '0 && rd_ang == cur_ang) begin
          if (dd_abs <= m1_q) begin
            m2_d  = m1_q;
            p2d_d = p1d_q;
            p2r_d = p1r_q;
            f2_d  = f1_q;
            m1_d  = dd_abs;
            p1d_d = rd_dist;
            p1r_d = rd_rat;
            f1_d  = 1'b1;
          end else if (dd_abs <= m2_q) begin
            m2_d  = dd_abs;
            p2d_d = rd_dist;
            p2r_d = rd_rat;
            f2_d  = 1'b1;
          end
        end
        if (cnt_q == CntW'(TableDepth)) begin
          st_d = SDEnd;
        end
      end
      SDEnd: begin
        st_d = SDFin;
        if (!f1_q) begin
          dval_d = '0;
        end else if (dlo == dhi || $signed(qd_q) <= $signed(dlo)) begin
          dval_d = rlo;
        end else if ($signed(qd_q) >= $signed(dhi)) begin
          dval_d = rhi;
        end else begin
          l_start = 1'b1;
          st_d    = SLerpD;
        end
      end
      SLerpD: begin
        if (l_done) begin
          dval_d = l_res[DataW-1:0];
          st_d   = SDFin;
        end
      end
      SDFin: begin
        if (single_q) begin
          ovld_d = 1'b1;
          ores_d = dval_q;
          osgl_d = 1'b1;
          st_d   = SIdle;
        end else if (!side_q) begin
          rlo_d  = dval_q;
          side_d = 1'b1;
          cnt_d  = '0;
          m1_d   = Window;
          m2_d   = Window;
          f1_d   = 1'b0;
          f2_d   = 1'b0;
          st_d   = SD;
        end else begin
          l_start = 1'b1;
          st_d    = SLerpA;
        end
      end
      SLerpA: begin
        if (l_done) begin
          ovld_d = 1'b1;
          ores_d = sat32(l_res);
          osgl_d = 1'b0;
          st_d   = SIdle;
        end
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= SClear;
      cnt_q  <= '0;
      ovld_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    osgl_q   <= osgl_d;
    ores_q   <= ores_d;
    waddr_q  <= waddr_d;
    wdata_q  <= wdata_d;
    a_q      <= a_d;
    qd_q     <= qd_d;
    m1_q     <= m1_d;
    m2_q     <= m2_d;
    f1_q     <= f1_d;
    f2_q     <= f2_d;
    ang1_q   <= ang1_d;
    alo_q    <= alo_d;
    ahi_q    <= ahi_d;
    p1d_q    <= p1d_d;
    p1r_q    <= p1r_d;
    p2d_q    <= p2d_d;
    p2r_q    <= p2r_d;
    rlo_q    <= rlo_d;
    dval_q   <= dval_d;
    side_q   <= side_d;
    single_q <= single_d;
  end

  assign busy_o               = (st_q != SIdle);
  assign result_valid_o       = ovld_q;
  assign interpolated_ratio_o = ores_q;
  assign single_angle_used_o  = osgl_q;

endmodule

FILE: hdl/stbi_ram.sv
module stbi_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/stbi_lerp.sv
module stbi_lerp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [stbi_pkg::DataW-1:0] r0_i,
  input  logic signed [stbi_pkg::DataW-1:0] r1_i,
  input  logic signed [stbi_pkg::DataW:0]   num_i,
  input  logic [stbi_pkg::DataW-1:0]        den_i,
  output logic                            done_o,
  output logic signed [63:0]              res_o
);
  import stbi_pkg::*;

  localparam logic [1:0] LIdle = 2'd0;
  localparam logic [1:0] LMul  = 2'd1;
  localparam logic [1:0] LDiv  = 2'd2;

  logic [1:0]            st_q, st_d;
  logic [5:0]            cnt_q, cnt_d;
  logic                  done_q, done_d;
  logic                  neg_q, neg_d;
  logic signed [DataW-1:0] r0_q, r0_d;
  logic [DataW-1:0]      mdr_q, mdr_d, mn_q, mn_d, den_q, den_d;
  logic [DataW-1:0]      rem_q, rem_d;
  logic [63:0]           quo_q, quo_d;
  logic signed [63:0]    res_q, res_d;
  logic signed [DataW:0] dr;
  logic [DataW:0]        trial;
  logic [63:0]           quo_new;

  // Magnitude and sign setup, one 32x32 multiply, then one quotient bit a cycle.
  always_comb begin
    st_d    = st_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    neg_d   = neg_q;
    r0_d    = r0_q;
    mdr_d   = mdr_q;
    mn_d    = mn_q;
    den_d   = den_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    res_d   = res_q;
    dr      = {r1_i[DataW-1], r1_i} - {r0_i[DataW-1], r0_i};
    trial   = {rem_q, quo_q[63]};
    quo_new = {quo_q[62:0], 1'b0};
    case (st_q)
      LIdle: begin
        if (start_i) begin
          r0_d  = r0_i;
          neg_d = dr[DataW] ^ num_i[DataW];
          mdr_d = dr[DataW] ? DataW'(-dr) : dr[DataW-1:0];
          mn_d  = num_i[DataW] ? DataW'(-num_i) : num_i[DataW-1:0];
          den_d = den_i;
          st_d  = LMul;
        end
      end
      LMul: begin
        quo_d = 64'(mdr_q) * 64'(mn_q);
        rem_d = '0;
        cnt_d = '0;
        st_d  = LDiv;
      end
      LDiv: begin
        if (trial >= {1'b0, den_q}) begin
          rem_d   = DataW'(trial - {1'b0, den_q});
          quo_new = {quo_q[62:0], 1'b1};
        end else begin
          rem_d = trial[DataW-1:0];
        end
        quo_d = quo_new;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          res_d  = 64'(r0_q) + (neg_q ? -$signed(quo_new) : $signed(quo_new));
          done_d = 1'b1;
          st_d   = LIdle;
        end
      end
      default: st_d = LIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= LIdle;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    r0_q  <= r0_d;
    mdr_q <= mdr_d;
    mn_q  <= mn_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: tb/stbi_checker.sv
// Watches the command, configuration and result channels of the lookup unit,
// keeps its own copy of the table and registers, and compares every result.
module stbi_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              busy_i,
  input  logic                              operation_i,
  input  logic [7:0]                        entry_index_i,
  input  logic signed [stbi_pkg::DataW-1:0] entry_distance_i,
  input  logic signed [stbi_pkg::DataW-1:0] entry_angle_i,
  input  logic signed [stbi_pkg::DataW-1:0] entry_ratio_i,
  input  logic signed [stbi_pkg::DataW-1:0] query_angle_i,
  input  logic signed [stbi_pkg::DataW-1:0] query_distance_i,
  input  logic                              result_valid_i,
  input  logic signed [stbi_pkg::DataW-1:0] interpolated_ratio_i,
  input  logic                              single_angle_used_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [1:0]                        cfg_index_i,
  input  logic [15:0]                       cfg_data_i,
  output int                                fail_count_o,
  output int                                pending_o
);
  import stbi_pkg::*;

  localparam int Depth = TableDepthDef;
  localparam longint WinQ = longint'(999) * 65536;

  typedef struct packed {
    logic [31:0] ratio;
    logic        single;
  } lookup_t;

  longint slide_q;
  longint widen_q;
  logic signed [31:0] pt_dist [Depth];
  logic signed [31:0] pt_ang [Depth];
  logic signed [31:0] pt_ratio [Depth];
  lookup_t lookup_q [$];

  function automatic longint clamp32(longint v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  function automatic longint mag(longint a, longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Linear blend with the step truncated toward zero.
  function automatic longint blend(longint r0, longint r1, longint num, longint den);
    longint dr;
    logic neg;
    logic [63:0] mdr, mn, q;
    dr = r1 - r0;
    neg = (dr < 0) != (num < 0);
    mdr = (dr < 0) ? -dr : dr;
    mn = (num < 0) ? -num : num;
    q = (mdr * mn) / $unsigned(den);
    return neg ? r0 - longint'(q) : r0 + longint'(q);
  endfunction

  // Distance interpolation among the points that share one angle.
  function automatic longint ratio_for_angle(longint ang, longint qdist);
    longint m1, m2, d, dlo, dhi, rlo, rhi, t;
    int i1, i2;
    logic v1, v2;
    m1 = WinQ; m2 = WinQ; i1 = 0; i2 = 0; v1 = 0; v2 = 0;
    for (int i = 0; i < Depth; i++) begin
      if (longint'(pt_ang[i]) == ang) begin
        d = mag(qdist, longint'(pt_dist[i]));
        if (d <= m1) begin
          m2 = m1; i2 = i1; v2 = v1;
          m1 = d; i1 = i; v1 = 1;
        end else if (d <= m2) begin
          m2 = d; i2 = i; v2 = 1;
        end
      end
    end
    if (!v1) return 0;
    if (!v2) i2 = i1;
    dlo = pt_dist[i1]; rlo = pt_ratio[i1];
    dhi = pt_dist[i2]; rhi = pt_ratio[i2];
    if (dlo > dhi) begin
      t = dlo; dlo = dhi; dhi = t;
      t = rlo; rlo = rhi; rhi = t;
    end
    if (dlo == dhi || qdist <= dlo) return rlo;
    if (qdist >= dhi) return rhi;
    return blend(rlo, rhi, qdist - dlo, dhi - dlo);
  endfunction

  function automatic lookup_t predict_lookup(longint qa, longint qd);
    lookup_t r;
    longint a, m1, m2, d, alo, ahi, t;
    int j1, j2;
    logic f1, f2;
    a = qa - slide_q * 65536;
    if (a < 0) a = -a;
    if (a > 64'sh7FFF_FFFF) a = 64'sh7FFF_FFFF;
    m1 = WinQ; m2 = WinQ; j1 = 0; j2 = 0; f1 = 0; f2 = 0;
    for (int i = 0; i < Depth; i++) begin
      d = mag(a, longint'(pt_ang[i]));
      if (d < m1) begin m1 = d; j1 = i; f1 = 1; end
    end
    if (!f1) begin
      r.ratio = '0; r.single = 1;
      return r;
    end
    for (int i = 0; i < Depth; i++) begin
      d = mag(a, longint'(pt_ang[i]));
      if (d < m2 && pt_ang[i] != pt_ang[j1]) begin m2 = d; j2 = i; f2 = 1; end
    end
    if (!f2) begin
      r.ratio = 32'(ratio_for_angle(pt_ang[j1], qd)); r.single = 1;
      return r;
    end
    alo = pt_ang[j1]; ahi = pt_ang[j2];
    if (alo > ahi) begin t = alo; alo = ahi; ahi = t; end
    r.ratio = 32'(clamp32(blend(ratio_for_angle(alo, qd), ratio_for_angle(ahi, qd),
                                a - alo, ahi - alo)));
    r.single = 0;
    return r;
  endfunction

  assign pending_o = lookup_q.size();

  // Track accepted words and compare results in order.
  always @(posedge clk_i or negedge rst_ni) begin
    longint p;
    lookup_t got, want;
    if (!rst_ni) begin
      slide_q = 0; widen_q = 256; fail_count_o = 0;
      lookup_q.delete();
      for (int i = 0; i < Depth; i++) begin
        pt_dist[i] = '0; pt_ang[i] = '0; pt_ratio[i] = '0;
      end
    end else begin
      if (result_valid_i) begin
        got.ratio = interpolated_ratio_i; got.single = single_angle_used_i;
        if (lookup_q.size() == 0) begin
          $error("unexpected result ratio=%h single=%b", got.ratio, got.single);
          fail_count_o++;
        end else begin
          want = lookup_q.pop_front();
          if (got.ratio !== want.ratio) begin
            $error("interpolated_ratio expected %h actual %h", want.ratio, got.ratio);
            fail_count_o++;
          end
          if (got.single !== want.single) begin
            $error("single_angle_used expected %b actual %b", want.single, got.single);
            fail_count_o++;
          end
        end
      end
      // A word taken at the same edge as a register write sees the old settings.
      if (start_i && !busy_i) begin
        if (!operation_i) begin
          // Floor shift of the widened angle, then saturate.
          p = (longint'(entry_angle_i) * widen_q) >>> 8;
          pt_dist[entry_index_i] = entry_distance_i;
          pt_ang[entry_index_i] = 32'(clamp32(p));
          pt_ratio[entry_index_i] = entry_ratio_i;
        end else begin
          lookup_q.push_back(predict_lookup(query_angle_i, query_distance_i));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == RegSlide) slide_q = longint'($signed(cfg_data_i[11:0]));
        else if (cfg_index_i == RegWiden) widen_q = longint'(cfg_data_i);
      end
    end
  end

endmodule

FILE: tb/tb_scattered_table_bilinear_interp_unit.sv
// Stimulus and verdict for the scattered-table lookup unit.
module tb_scattered_table_bilinear_interp_unit;
  import stbi_pkg::*;

  localparam int OpWrite = 0;
  localparam int OpQuery = 1;
  localparam int CycleLimit = 3_000_000;

  // Index past the last register, which the unit ignores.
  localparam logic [1:0] RegBad = 2'd3;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start_i = 0;
  logic operation_i = 0;
  logic [7:0] entry_index_i = '0;
  logic signed [31:0] entry_distance_i = '0, entry_angle_i = '0, entry_ratio_i = '0;
  logic signed [31:0] query_angle_i = '0, query_distance_i = '0;
  logic cfg_valid_i = 0;
  logic [1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic busy_o, result_valid_o, single_angle_used_o, cfg_ready_o;
  logic signed [31:0] interpolated_ratio_o;
  int fail_count, pending, idle_pct;
  int cycles = 0;

  always #10 clk_i = ~clk_i;

  scattered_table_bilinear_interp_unit u_top (.*);

  stbi_checker u_chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .operation_i, .entry_index_i,
    .entry_distance_i, .entry_angle_i, .entry_ratio_i, .query_angle_i,
    .query_distance_i, .result_valid_i(result_valid_o),
    .interpolated_ratio_i(interpolated_ratio_o),
    .single_angle_used_i(single_angle_used_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o),
    .cfg_index_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog on total cycles.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Send one word and hold it until the unit takes it. Busy is sampled mid-cycle
  // so the accepting edge is known exactly.
  task automatic send_word(int op, int idx, logic [31:0] d, logic [31:0] ang,
                           logic [31:0] r, logic [31:0] qa, logic [31:0] qd);
    logic acc;
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 0;
      @(posedge clk_i);
    end
    start_i <= 1; operation_i <= op[0]; entry_index_i <= idx[7:0];
    entry_distance_i <= d; entry_angle_i <= ang; entry_ratio_i <= r;
    query_angle_i <= qa; query_distance_i <= qd;
    do begin
      @(negedge clk_i);
      acc = !busy_o;
      @(posedge clk_i);
    end while (!acc);
  endtask

  // Stop sending and wait until the unit is idle with no result outstanding.
  task automatic drain();
    start_i <= 0;
    do @(negedge clk_i); while (pending != 0 || busy_o);
    @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] v);
    drain();
    cfg_valid_i <= 1; cfg_index_i <= idx; cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 0;
  endtask

  // Angles and distances near a small set of values so the windows catch points.
  function automatic logic [31:0] near_q16(int span);
    return 32'($signed($urandom_range(2 * span)) - span) * 32'sd65536 / 4
           + 32'($urandom_range(65535));
  endfunction

  task automatic random_word();
    int k;
    k = $urandom_range(99);
    if (k < 5)
      send_word($urandom_range(1), $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    else if (k < 45)
      send_word(OpWrite, $urandom_range(255), near_q16(40), near_q16(16),
                $urandom, 0, 0);
    else
      send_word(OpQuery, 0, 0, 0, 0, near_q16(16), near_q16(40));
  endtask

  initial begin
    idle_pct = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);

    // Directed: empty table, extremes, exact matches, ties, clamping.
    send_word(OpQuery, 0, 0, 0, 0, 0, 0);
    send_word(OpQuery, 0, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(OpWrite, 0, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 0, 0);
    send_word(OpQuery, 0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000);
    send_word(OpWrite, 1, 32'h0005_0000, 32'h0001_0000, 32'hFFFE_0000, 0, 0);
    send_word(OpWrite, 2, 32'h0005_0000, 32'h0001_0000, 32'h0007_0000, 0, 0);
    send_word(OpQuery, 0, 0, 0, 0, 32'h0001_0000, 32'h0003_4000);
    send_word(OpQuery, 0, 0, 0, 0, 32'h0001_0000, 32'h7FFF_FFFF);
    send_word(OpQuery, 0, 0, 0, 0, 32'h0001_0000, 32'h8000_0000);
    send_word(OpWrite, 3, 32'h0002_0000, 32'h0004_0000, 32'h7FFF_FFFF, 0, 0);
    send_word(OpQuery, 0, 0, 0, 0, 32'h0002_8000, 32'h0002_0000);
    send_word(OpQuery, 0, 0, 0, 0, 32'hFFFA_0000, 32'h0003_0000);
    send_word(OpWrite, 4, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
    send_word(OpWrite, 255, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
    send_word(OpQuery, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(OpQuery, 0, 0, 0, 0, 32'h0010_0000, 32'h0001_0000);

    // Configuration extremes, with writes under each widen setting and a query under each slide setting.
    write_reg(RegWiden, 16'hFFFF);
    send_word(OpWrite, 5, 32'h0001_0000, 32'h7FFF_FFFF, 32'h0003_0000, 0, 0);
    send_word(OpWrite, 6, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0003_0000, 0, 0);
    write_reg(RegWiden, 16'h0000);
    send_word(OpWrite, 7, 32'h0001_0000, 32'h1234_5678, 32'h0004_0000, 0, 0);
    write_reg(RegSlide, 16'h0400);
    send_word(OpQuery, 0, 0, 0, 0, 32'h8000_0000, 32'h0001_0000);
    write_reg(RegSlide, 16'h0C00);
    send_word(OpQuery, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h0001_0000);
    write_reg(RegBad, 16'hFFFF);
    write_reg(RegSlide, 16'h0000);
    write_reg(RegWiden, 16'd256);

    // Random phases with different sender idling, the settings changed between.
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 33 : (ph == 1) ? 85 : 0;
      if (ph == 1) write_reg(RegWiden, 16'd384);
      if (ph == 2) begin
        write_reg(RegWiden, 16'd256);
        write_reg(RegSlide, 16'h0FFE);
      end
      for (int n = 0; n < 200; n++) begin
        random_word();
        if (n == 100) drain();
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

FILE: files.f
hdl/stbi_pkg.sv
hdl/stbi_ram.sv
hdl/stbi_lerp.sv
hdl/scattered_table_bilinear_interp_unit.sv
tb/stbi_checker.sv
tb/tb_scattered_table_bilinear_interp_unit.sv
